// ===== rtl/tods_pkg.sv =====
// ----------------------------------------------------------------------------
// tods_pkg
// Shared widths, codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package tods_pkg;

    localparam int TIME_W  = 17;
    localparam int STOP_W  = 18;
    localparam int DELAY_W = 16;
    localparam int ID_W    = 4;
    localparam int MODE_W  = 3;
    localparam int EV_W    = 3;
    localparam int KIND_W  = 2;
    localparam int OP_W    = 2;

    localparam int DATA_IN_W  = 72;
    localparam int DATA_OUT_W = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WINDOW = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ONCE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REPEAT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DAILY  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd5;

    localparam logic [KIND_W-1:0] KIND_WINDOW = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ONCE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd3;

    localparam logic [EV_W-1:0] EV_START   = 3'd0;
    localparam logic [EV_W-1:0] EV_STOP    = 3'd1;
    localparam logic [EV_W-1:0] EV_ADDED   = 3'd2;
    localparam logic [EV_W-1:0] EV_FULL    = 3'd3;
    localparam logic [EV_W-1:0] EV_REMOVED = 3'd4;
    localparam logic [EV_W-1:0] EV_DONE    = 3'd5;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_IGNORE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] start;
        logic [STOP_W-1:0] stop;
        logic [ID_W-1:0]   id;
    } tods_cmd_t;

endpackage

// ===== rtl/tods_mod.sv =====
// ----------------------------------------------------------------------------
// tods_mod
// Remainder by the day length through reciprocal multiplication.
// ----------------------------------------------------------------------------
module tods_mod
    import tods_pkg::*;
#(
    parameter int DAY_SECONDS = 86400
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [STOP_W-1:0] dividend,
    output logic              done,
    output logic [TIME_W-1:0] rem
);

    // (x * RECIP) >> SHIFT gives the exact quotient for every STOP_W-bit x
    localparam int     SHIFT   = STOP_W + $clog2(DAY_SECONDS);
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DAY_SECONDS)
                                  - longint'(1)) / longint'(DAY_SECONDS);
    localparam int     PROD_W  = 2 * STOP_W + 1;

    localparam logic [STOP_W:0]   RECIP   = (STOP_W + 1)'(RECIP_L);
    localparam logic [TIME_W-1:0] DIVISOR = TIME_W'(DAY_SECONDS);

    logic              stage1_reg;
    logic              stage2_reg;
    logic              done_reg;
    logic [STOP_W-1:0] num_reg;
    logic [TIME_W-1:0] quot_reg;
    logic [TIME_W-1:0] rem_reg;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_shr;
    logic [TIME_W-1:0] quot_times_d;
    logic [TIME_W-1:0] rem_full;

    // the remainder is below 2^TIME_W, so the low bits of the difference suffice
    always_comb
    begin
        prod         = PROD_W'(num_reg) * PROD_W'(RECIP);
        prod_shr     = prod >> SHIFT;
        quot_times_d = quot_reg * DIVISOR;
        rem_full     = num_reg[TIME_W-1:0] - quot_times_d;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            stage1_reg <= start;
            stage2_reg <= stage1_reg;
            done_reg   <= stage2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
        end
        if (stage1_reg)
        begin
            quot_reg <= prod_shr[TIME_W-1:0];
        end
        if (stage2_reg)
        begin
            rem_reg <= rem_full;
        end
    end

endmodule

// ===== rtl/tods_front.sv =====
// ----------------------------------------------------------------------------
// tods_front
// Accepts items, reduces times to the day and builds commands for the back.
// ----------------------------------------------------------------------------
module tods_front
    import tods_pkg::*;
#(
    parameter int DAY_SECONDS = 86400
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [MODE_W-1:0]  mode,
    input  logic [TIME_W-1:0]  now_time,
    input  logic [TIME_W-1:0]  start_time,
    input  logic [TIME_W-1:0]  stop_time,
    input  logic [DELAY_W-1:0] delay_seconds,
    input  logic [ID_W-1:0]    task_id,
    output logic               q_push,
    output tods_cmd_t          q_data,
    input  logic               q_full
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD1 = 2'd1;
    localparam logic [1:0] S_MOD2 = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [TIME_W-1:0]  stop_in_reg, stop_in_next;
    logic [DELAY_W-1:0] dly_reg, dly_next;
    tods_cmd_t          cmd_reg, cmd_next;

    logic               mod_start;
    logic [STOP_W-1:0]  mod_dividend;
    logic               mod_done;
    logic [TIME_W-1:0]  mod_rem;

    tods_mod #(
        .DAY_SECONDS (DAY_SECONDS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign q_data   = cmd_reg;

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        stop_in_next = stop_in_reg;
        dly_next     = dly_reg;
        cmd_next     = cmd_reg;
        mod_start    = 1'b0;
        mod_dividend = {1'b0, start_time};
        q_push       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next     = mode;
                    stop_in_next  = stop_time;
                    dly_next      = delay_seconds;
                    cmd_next.now  = now_time;
                    cmd_next.id   = task_id;
                    cmd_next.kind = KIND_WINDOW;
                    case (mode)
                        MODE_TICK:
                        begin
                            cmd_next.op = OP_TICK;
                            state_next  = S_PUSH;
                        end
                        MODE_WINDOW:
                        begin
                            cmd_next.op = OP_ADD;
                            mod_start   = 1'b1;
                            state_next  = S_MOD1;
                        end
                        MODE_ONCE, MODE_REPEAT:
                        begin
                            cmd_next.op   = OP_ADD;
                            cmd_next.kind = (mode == MODE_ONCE) ? KIND_ONCE : KIND_REPEAT;
                            mod_dividend  = {1'b0, now_time} + {2'b00, delay_seconds};
                            mod_start     = 1'b1;
                            state_next    = S_MOD1;
                        end
                        MODE_DAILY:
                        begin
                            cmd_next.op   = OP_ADD;
                            cmd_next.kind = KIND_REPEAT;
                            mod_start     = 1'b1;
                            state_next    = S_MOD1;
                        end
                        MODE_REMOVE:
                        begin
                            cmd_next.op = OP_REMOVE;
                            state_next  = S_PUSH;
                        end
                        default:
                        begin
                            cmd_next.op = OP_IGNORE;
                            state_next  = S_PUSH;
                        end
                    endcase
                end
            end
            S_MOD1:
            begin
                mod_dividend = {1'b0, stop_in_reg};
                if (mod_done)
                begin
                    cmd_next.start = mod_rem;
                    if (mode_reg == MODE_WINDOW)
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MOD2;
                    end
                    else if (mode_reg == MODE_DAILY)
                    begin
                        cmd_next.stop = {1'b0, mod_rem} + STOP_W'(1);
                        state_next    = S_PUSH;
                    end
                    else
                    begin
                        cmd_next.stop = {1'b0, mod_rem} + {2'b00, dly_reg};
                        state_next    = S_PUSH;
                    end
                end
            end
            S_MOD2:
            begin
                if (mod_done)
                begin
                    cmd_next.stop = {1'b0, mod_rem};
                    state_next    = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        stop_in_reg <= stop_in_next;
        dly_reg     <= dly_next;
        cmd_reg     <= cmd_next;
    end

endmodule

// ===== rtl/tods_queue.sv =====
// ----------------------------------------------------------------------------
// tods_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tods_queue
    import tods_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tods_cmd_t push_data,
    output logic      full,
    input  logic      pop,
    output tods_cmd_t pop_data,
    output logic      empty
);

    tods_cmd_t         slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

// ===== rtl/tods_back.sv =====
// ----------------------------------------------------------------------------
// tods_back
// Task table and its walker: ticks, adds, removes and the result register.
// ----------------------------------------------------------------------------
module tods_back
    import tods_pkg::*;
#(
    parameter int MAX_TASKS   = 16,
    parameter int DAY_SECONDS = 86400
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  tods_cmd_t       q_data,
    input  logic            q_empty,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [EV_W-1:0] event_res,
    output logic [ID_W-1:0] entry_id,
    output logic            last
);

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int UW = $clog2(MAX_TASKS + 1);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_READ      = 4'd1;
    localparam logic [3:0] ST_TICK_EVAL = 4'd2;
    localparam logic [3:0] ST_MODW      = 4'd3;
    localparam logic [3:0] ST_ADD_EVAL  = 4'd4;
    localparam logic [3:0] ST_APPEND    = 4'd5;
    localparam logic [3:0] ST_REMOVE    = 4'd6;
    localparam logic [3:0] ST_DONE      = 4'd7;

    // table storage
    logic [TIME_W-1:0] mem_start [MAX_TASKS];
    logic [STOP_W-1:0] mem_stop  [MAX_TASKS];
    logic [KIND_W-1:0] mem_kind  [MAX_TASKS];
    logic              mem_run   [MAX_TASKS];

    logic [TIME_W-1:0] rd_start;
    logic [STOP_W-1:0] rd_stop;
    logic [KIND_W-1:0] rd_kind;
    logic              rd_run;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    logic              we_start, we_stop, we_kind, we_run;
    logic [AW-1:0]     wr_addr;
    logic [TIME_W-1:0] wr_start;
    logic [STOP_W-1:0] wr_stop;
    logic [KIND_W-1:0] wr_kind;
    logic              wr_run;

    logic [3:0]         state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [UW-1:0]      used_reg, used_next;
    tods_cmd_t          cur_reg, cur_next;
    logic [DELAY_W-1:0] span_reg, span_next;

    logic               out_valid_reg;
    logic [EV_W-1:0]    out_ev_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic               out_last_reg;
    logic               out_free;
    logic               emit;
    logic [EV_W-1:0]    emit_ev;
    logic [ID_W-1:0]    emit_id;
    logic               emit_last;

    logic               mod_start;
    logic [STOP_W-1:0]  mod_dividend;
    logic               mod_done;
    logic [TIME_W-1:0]  mod_rem;

    logic [STOP_W-1:0]  s18, n18, diff;
    logic [DELAY_W-1:0] span_cur;
    logic               fwd, rev, do_fire, do_stop, need_emit, resched, more;
    logic [AW-1:0]      idx_plus;

    tods_mod #(
        .DAY_SECONDS (DAY_SECONDS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign m_tvalid  = out_valid_reg;
    assign event_res = out_ev_reg;
    assign entry_id  = out_id_reg;
    assign last      = out_last_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // decode the entry just read against the tick time
    always_comb
    begin
        s18       = {1'b0, rd_start};
        n18       = {1'b0, cur_reg.now};
        diff      = rd_stop - s18;
        span_cur  = diff[DELAY_W-1:0];
        fwd       = (rd_kind != KIND_FREE) && (s18 < rd_stop);
        rev       = !fwd && (rd_kind == KIND_WINDOW) && (s18 > rd_stop);
        do_fire   = !rd_run && ((fwd && (n18 >= s18) && (n18 < rd_stop)) ||
                                (rev && (n18 > s18) && (n18 > rd_stop)));
        do_stop   = !do_fire && rd_run &&
                    ((fwd && (n18 > s18) && (n18 >= rd_stop)) ||
                     (rev && (n18 < s18) && (n18 > rd_stop)));
        need_emit = do_fire || (do_stop && (rd_kind == KIND_WINDOW));
        resched   = do_fire && (rd_kind == KIND_REPEAT) && (span_cur != DELAY_W'(1));
        more      = (UW'(idx_reg) + UW'(1)) < used_reg;
        idx_plus  = idx_reg + AW'(1);
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        used_next    = used_reg;
        cur_next     = cur_reg;
        span_next    = span_reg;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        we_start     = 1'b0;
        we_stop      = 1'b0;
        we_kind      = 1'b0;
        we_run       = 1'b0;
        wr_addr      = idx_reg;
        wr_start     = cur_reg.start;
        wr_stop      = cur_reg.stop;
        wr_kind      = cur_reg.kind;
        wr_run       = 1'b0;
        emit         = 1'b0;
        emit_ev      = EV_DONE;
        emit_id      = '0;
        emit_last    = 1'b1;
        mod_start    = 1'b0;
        mod_dividend = n18 + {2'b00, span_cur};

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_data;
                    idx_next = '0;
                    case (q_data.op)
                        OP_TICK:   state_next = (used_reg == '0) ? ST_DONE : ST_READ;
                        OP_ADD:    state_next = (used_reg == '0) ? ST_APPEND : ST_READ;
                        OP_REMOVE: state_next = ST_REMOVE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = (cur_reg.op == OP_TICK) ? ST_TICK_EVAL : ST_ADD_EVAL;
            end
            ST_TICK_EVAL:
            begin
                // hold while an event waits for the result register
                if (!need_emit || out_free)
                begin
                    if (need_emit)
                    begin
                        emit      = 1'b1;
                        emit_ev   = do_fire ? EV_START : EV_STOP;
                        emit_id   = ID_W'(idx_reg);
                        emit_last = 1'b0;
                    end
                    if (do_fire)
                    begin
                        we_run = 1'b1;
                        wr_run = 1'b1;
                        if (rd_kind == KIND_ONCE)
                        begin
                            we_kind = 1'b1;
                            wr_kind = KIND_FREE;
                        end
                    end
                    if (do_stop)
                    begin
                        we_run = 1'b1;
                        wr_run = 1'b0;
                    end
                    if (resched)
                    begin
                        mod_start  = 1'b1;
                        span_next  = span_cur;
                        state_next = ST_MODW;
                    end
                    else if (more)
                    begin
                        idx_next = idx_plus;
                        rd_en    = 1'b1;
                        rd_addr  = idx_plus;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MODW:
            begin
                if (mod_done)
                begin
                    we_start = 1'b1;
                    we_stop  = 1'b1;
                    we_run   = 1'b1;
                    wr_start = mod_rem;
                    wr_stop  = {1'b0, mod_rem} + {2'b00, span_reg};
                    wr_run   = 1'b0;
                    if (more)
                    begin
                        idx_next   = idx_plus;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ADD_EVAL:
            begin
                if (rd_kind == KIND_FREE)
                begin
                    if (out_free)
                    begin
                        we_start   = 1'b1;
                        we_stop    = 1'b1;
                        we_kind    = 1'b1;
                        we_run     = 1'b1;
                        emit       = 1'b1;
                        emit_ev    = EV_ADDED;
                        emit_id    = ID_W'(idx_reg);
                        state_next = ST_IDLE;
                    end
                end
                else if (more)
                begin
                    idx_next = idx_plus;
                    rd_en    = 1'b1;
                    rd_addr  = idx_plus;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (32'(used_reg) < MAX_TASKS)
                    begin
                        wr_addr   = AW'(used_reg);
                        we_start  = 1'b1;
                        we_stop   = 1'b1;
                        we_kind   = 1'b1;
                        we_run    = 1'b1;
                        used_next = used_reg + UW'(1);
                        emit_ev   = EV_ADDED;
                        emit_id   = ID_W'(used_reg);
                    end
                    else
                    begin
                        emit_ev = EV_FULL;
                    end
                end
            end
            ST_REMOVE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (32'(cur_reg.id) < 32'(used_reg))
                    begin
                        wr_addr = AW'(cur_reg.id);
                        we_kind = 1'b1;
                        wr_kind = KIND_FREE;
                        emit_ev = EV_REMOVED;
                        emit_id = cur_reg.id;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_start)
        begin
            mem_start[wr_addr] <= wr_start;
        end
        if (we_stop)
        begin
            mem_stop[wr_addr] <= wr_stop;
        end
        if (we_kind)
        begin
            mem_kind[wr_addr] <= wr_kind;
        end
        if (we_run)
        begin
            mem_run[wr_addr] <= wr_run;
        end
        if (rd_en)
        begin
            rd_start <= mem_start[rd_addr];
            rd_stop  <= mem_stop[rd_addr];
            rd_kind  <= mem_kind[rd_addr];
            rd_run   <= mem_run[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cur_reg  <= cur_next;
        span_reg <= span_next;
        if (emit)
        begin
            out_ev_reg   <= emit_ev;
            out_id_reg   <= emit_id;
            out_last_reg <= emit_last;
        end
    end

    a_used_bound : assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= MAX_TASKS)
        else $error("table fill count beyond table size");

    a_mod_only_when_waiting : assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_MODW))
        else $error("reschedule remainder arrived outside its wait state");

    a_walk_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK_EVAL) |-> (32'(idx_reg) < 32'(used_reg)))
        else $error("tick walk past the used entries");

    a_added_fills : assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (emit_ev == EV_ADDED)) |=> (used_reg != '0))
        else $error("entry added to an empty table");

endmodule

// ===== rtl/time_of_day_task_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// time_of_day_task_scheduler_top
// Time-of-day task table: windows, one-shots and repeating intervals.
// ----------------------------------------------------------------------------
// A tick or remove passes from the front to the queue directly, an add after one pass
// through the remainder unit and a window add after two (one for each time reduced).
// The back walks the used entries on a tick (waiting on the remainder unit for each
// interval that reschedules) and on an add, handles a remove without a walk, and may stall.
// The front takes a new item while the back still works the previous one.
// Reset clears the fill count and control only; table entries are undefined until written.
module time_of_day_task_scheduler_top
    import tods_pkg::*;
#(
    parameter int MAX_TASKS   = 16,
    parameter int DAY_SECONDS = 86400
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_time[16:0], start_time[33:17], stop_time[50:34],
    // delay_seconds[66:51], task_id[70:67], zero pad
    input  logic [DATA_IN_W-1:0]  s_tdata,
    // mode[2:0]
    input  logic [MODE_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // entry_id[3:0], zero pad
    output logic [DATA_OUT_W-1:0] m_tdata,
    // event_res[2:0]
    output logic [EV_W-1:0]       m_tuser,
    output logic                  m_tlast
);

    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    tods_cmd_t q_in;
    tods_cmd_t q_out;
    logic [ID_W-1:0] entry_id;

    tods_front #(
        .DAY_SECONDS (DAY_SECONDS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .mode          (s_tuser),
        .now_time      (s_tdata[16:0]),
        .start_time    (s_tdata[33:17]),
        .stop_time     (s_tdata[50:34]),
        .delay_seconds (s_tdata[66:51]),
        .task_id       (s_tdata[70:67]),
        .q_push        (q_push),
        .q_data        (q_in),
        .q_full        (q_full)
    );

    tods_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    tods_back #(
        .MAX_TASKS   (MAX_TASKS),
        .DAY_SECONDS (DAY_SECONDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_out),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .event_res (m_tuser),
        .entry_id  (entry_id),
        .last      (m_tlast)
    );

    assign m_tdata = {{(DATA_OUT_W - ID_W){1'b0}}, entry_id};

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the time-of-day task scheduler against a cycle-free table model.
// Directed items cover empty-table ticks, midnight windows, one-shots, daily
// and long intervals, removes and a full table. Random items follow a moving
// wall clock. Both stream sides stall at random, with one long output hold.
// ----------------------------------------------------------------------------
module testbench
    import tods_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ENTRIES = 16;
    localparam int DAY_SEC     = 86400;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 400;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [EV_W-1:0] ev;
        logic [ID_W-1:0] id;
        logic            last;
    } sched_event_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_IN_W-1:0]  s_tdata  = '0;
    logic [MODE_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_tdata;
    logic [EV_W-1:0]       m_tuser;
    logic                  m_tlast;

    // table copy kept in step with the block
    logic [TIME_W-1:0] tbl_start   [NUM_ENTRIES];
    logic [STOP_W-1:0] tbl_stop    [NUM_ENTRIES];
    logic [KIND_W-1:0] tbl_kind    [NUM_ENTRIES];
    logic              tbl_running [NUM_ENTRIES];
    int                tbl_used = 0;

    sched_event_t pending_events[$];

    bit src_idle     = 1'b1;
    bit sink_idle    = 1'b1;
    bit hold_request = 1'b0;
    int wall_clock   = 0;

    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int starts_seen   = 0;
    int stops_seen    = 0;
    int full_seen     = 0;

    time_of_day_task_scheduler_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------
    function automatic void push_event(logic [EV_W-1:0] ev, int id, logic last);
        sched_event_t e;
        e.ev   = ev;
        e.id   = id[ID_W-1:0];
        e.last = last;
        pending_events.push_back(e);
    endfunction

    function automatic void predict_add(int start_s, int stop_s, logic [KIND_W-1:0] kind);
        int slot;
        int i;
        slot = -1;
        for (i = 0; i < tbl_used; i++)
        begin
            if (slot < 0 && tbl_kind[i] == KIND_FREE)
                slot = i;
        end
        if (slot < 0)
        begin
            if (tbl_used >= NUM_ENTRIES)
            begin
                push_event(EV_FULL, 0, 1'b1);
                return;
            end
            slot = tbl_used;
            tbl_used++;
        end
        tbl_start[slot]   = start_s[TIME_W-1:0];
        tbl_stop[slot]    = stop_s[STOP_W-1:0];
        tbl_kind[slot]    = kind;
        tbl_running[slot] = 1'b0;
        push_event(EV_ADDED, slot, 1'b1);
    endfunction

    function automatic void fire_entry(int i, int now);
        int span;
        int next_start;
        tbl_running[i] = 1'b1;
        if (tbl_kind[i] == KIND_ONCE)
            tbl_kind[i] = KIND_FREE;
        push_event(EV_START, i, 1'b0);
        if (tbl_kind[i] == KIND_REPEAT)
        begin
            span = (int'(tbl_stop[i]) - int'(tbl_start[i])) & 16'hFFFF;
            // a daily entry keeps running until its stop second passes
            if (span != 1)
            begin
                next_start     = (now + span) % DAY_SEC;
                tbl_running[i] = 1'b0;
                tbl_start[i]   = next_start[TIME_W-1:0];
                tbl_stop[i]    = STOP_W'(next_start + span);
            end
        end
    endfunction

    function automatic void predict_tick(int now);
        int i;
        int s;
        int e;
        logic [KIND_W-1:0] k;
        logic run;
        for (i = 0; i < tbl_used; i++)
        begin
            s   = tbl_start[i];
            e   = tbl_stop[i];
            k   = tbl_kind[i];
            run = tbl_running[i];
            if (k != KIND_FREE && s < e)
            begin
                if (now >= s && now < e && !run)
                    fire_entry(i, now);
                else if (now > s && now >= e && run)
                begin
                    tbl_running[i] = 1'b0;
                    if (k == KIND_WINDOW)
                        push_event(EV_STOP, i, 1'b0);
                end
            end
            else if (k == KIND_WINDOW && s > e)
            begin
                // window across midnight
                if (now > s && now > e && !run)
                    fire_entry(i, now);
                else if (now < s && now > e && run)
                begin
                    tbl_running[i] = 1'b0;
                    push_event(EV_STOP, i, 1'b0);
                end
            end
        end
        push_event(EV_DONE, 0, 1'b1);
    endfunction

    function automatic void predict_item(logic [MODE_W-1:0] mode, int now, int st, int sp,
                                         int dly, int id);
        int s;
        case (mode)
            MODE_TICK:   predict_tick(now);
            MODE_WINDOW: predict_add(st % DAY_SEC, sp % DAY_SEC, KIND_WINDOW);
            MODE_ONCE:
            begin
                s = (now + dly) % DAY_SEC;
                predict_add(s, s + dly, KIND_ONCE);
            end
            MODE_REPEAT:
            begin
                s = (now + dly) % DAY_SEC;
                predict_add(s, s + dly, KIND_REPEAT);
            end
            MODE_DAILY:
            begin
                s = st % DAY_SEC;
                predict_add(s, s + 1, KIND_REPEAT);
            end
            MODE_REMOVE:
            begin
                if (id < tbl_used)
                begin
                    tbl_kind[id] = KIND_FREE;
                    push_event(EV_REMOVED, id, 1'b1);
                end
                else
                    push_event(EV_DONE, 0, 1'b1);
            end
            default: push_event(EV_DONE, 0, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stream drivers
    // ------------------------------------------------------------------
    task automatic send_item(logic [MODE_W-1:0] mode, int now, int st, int sp,
                             int dly, int id);
        logic [TIME_W-1:0]  now_f;
        logic [TIME_W-1:0]  st_f;
        logic [TIME_W-1:0]  sp_f;
        logic [DELAY_W-1:0] dly_f;
        logic [ID_W-1:0]    id_f;
        now_f = now[TIME_W-1:0];
        st_f  = st[TIME_W-1:0];
        sp_f  = sp[TIME_W-1:0];
        dly_f = dly[DELAY_W-1:0];
        id_f  = id[ID_W-1:0];
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, id_f, dly_f, sp_f, st_f, now_f};
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(mode, now_f, st_f, sp_f, dly_f, id_f);
        items_sent++;
    endtask

    // hold the input until every expected result is out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_events.size() != 0);
    endtask

    initial
    begin
        @(posedge clk iff rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (sink_idle && $urandom_range(0, 6) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        sched_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_events.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, got event %0d entry %0d last %0b",
                         $time, m_tuser, m_tdata[ID_W-1:0], m_tlast);
            end
            else
            begin
                want = pending_events.pop_front();
                case (want.ev)
                    EV_START: starts_seen++;
                    EV_STOP:  stops_seen++;
                    EV_FULL:  full_seen++;
                    default:  ;
                endcase
                if (m_tuser !== want.ev)
                begin
                    error_count++;
                    $display("%0t: event_res mismatch, expected %0d, got %0d",
                             $time, want.ev, m_tuser);
                end
                if (m_tdata[ID_W-1:0] !== want.id)
                begin
                    error_count++;
                    $display("%0t: entry_id mismatch, expected %0d, got %0d",
                             $time, want.id, m_tdata[ID_W-1:0]);
                end
                if (m_tlast !== want.last)
                begin
                    error_count++;
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------
    task automatic send_random_item();
        int r;
        int st;
        int sp;
        int dly;
        r = $urandom_range(0, 99);
        // advance the wall clock, now and then jump close to midnight
        if ($urandom_range(0, 19) == 0)
            wall_clock = $urandom_range(86000, DAY_SEC - 1);
        else
            wall_clock = (wall_clock + $urandom_range(0, 120)) % DAY_SEC;
        dly = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 150);
        if (r < 35)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(MODE_TICK, $urandom_range(0, DAY_SEC - 1), $urandom_range(0, DAY_SEC - 1),
                          $urandom_range(0, DAY_SEC - 1), $urandom_range(0, 65535),
                          $urandom_range(0, 15));
            else
                send_item(MODE_TICK, wall_clock, $urandom_range(0, DAY_SEC - 1),
                          $urandom_range(0, DAY_SEC - 1), $urandom_range(0, 65535),
                          $urandom_range(0, 15));
        end
        else if (r < 50)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                st = $urandom_range(0, DAY_SEC - 1);
                sp = $urandom_range(0, DAY_SEC - 1);
            end
            else
            begin
                st = (wall_clock + $urandom_range(0, 200)) % DAY_SEC;
                sp = (st + $urandom_range(1, 400)) % DAY_SEC;
            end
            send_item(MODE_WINDOW, $urandom_range(0, DAY_SEC - 1), st, sp,
                      $urandom_range(0, 65535), $urandom_range(0, 15));
        end
        else if (r < 58)
            send_item(MODE_ONCE, wall_clock, $urandom_range(0, DAY_SEC - 1),
                      $urandom_range(0, DAY_SEC - 1), dly, $urandom_range(0, 15));
        else if (r < 67)
            send_item(MODE_REPEAT, wall_clock, $urandom_range(0, DAY_SEC - 1),
                      $urandom_range(0, DAY_SEC - 1), dly, $urandom_range(0, 15));
        else if (r < 73)
            send_item(MODE_DAILY, $urandom_range(0, DAY_SEC - 1),
                      (wall_clock + $urandom_range(0, 100)) % DAY_SEC,
                      $urandom_range(0, DAY_SEC - 1), $urandom_range(0, 65535),
                      $urandom_range(0, 15));
        else if (r < 97)
            send_item(MODE_REMOVE, $urandom_range(0, DAY_SEC - 1), $urandom_range(0, DAY_SEC - 1),
                      $urandom_range(0, DAY_SEC - 1), $urandom_range(0, 65535),
                      $urandom_range(0, 15));
        else
            send_item(($urandom_range(0, 1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO,
                      $urandom_range(0, DAY_SEC - 1), $urandom_range(0, DAY_SEC - 1),
                      $urandom_range(0, DAY_SEC - 1), $urandom_range(0, 65535),
                      $urandom_range(0, 15));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // empty table, out-of-range removes, spare modes
        send_item(MODE_TICK, 0, 0, 0, 0, 0);
        send_item(MODE_REMOVE, 0, 0, 0, 0, 0);
        send_item(MODE_REMOVE, 0, 0, 0, 0, 15);
        send_item(MODE_SPARE_LO, DAY_SEC - 1, DAY_SEC - 1, DAY_SEC - 1, 65535, 15);
        send_item(MODE_SPARE_HI, 0, 0, 0, 0, 0);
        // window, midnight window, empty window
        send_item(MODE_WINDOW, 0, 100, 200, 0, 0);
        send_item(MODE_WINDOW, 0, 86000, 100, 0, 0);
        send_item(MODE_WINDOW, 0, 500, 500, 0, 0);
        // one-shot, zero-delay one-shot, longest interval from day end
        send_item(MODE_ONCE, 0, 0, 0, 10, 0);
        send_item(MODE_ONCE, 1000, 0, 0, 0, 0);
        send_item(MODE_REPEAT, DAY_SEC - 1, 0, 0, 65535, 0);
        send_item(MODE_DAILY, 0, 0, 0, 0, 0);
        send_item(MODE_DAILY, 0, DAY_SEC - 1, 0, 0, 0);
        send_item(MODE_TICK, 0, 0, 0, 0, 0);
        send_item(MODE_TICK, 15, 0, 0, 0, 0);
        send_item(MODE_TICK, 150, 0, 0, 0, 0);
        send_item(MODE_TICK, 250, 0, 0, 0, 0);
        send_item(MODE_TICK, DAY_SEC - 1, 0, 0, 0, 0);
        send_item(MODE_TICK, 200, 0, 0, 0, 0);
        // freed one-shot slot is reused, double remove, remove past the end
        send_item(MODE_ONCE, 5, 0, 0, 3, 0);
        send_item(MODE_REMOVE, 0, 0, 0, 0, 3);
        send_item(MODE_REMOVE, 0, 0, 0, 0, 3);
        send_item(MODE_REMOVE, 0, 0, 0, 0, 8);
        send_item(MODE_TICK, 65535, 0, 0, 0, 0);
        wait_drain();
    endtask

    task automatic test_table_full();
        int i;
        for (i = 0; i < 11; i++)
            send_item(MODE_WINDOW, 0, 1000 + i, 2000 + i, 0, 0);
        send_item(MODE_REMOVE, 0, 0, 0, 0, 15);
        send_item(MODE_REMOVE, 0, 0, 0, 0, 0);
        send_item(MODE_REPEAT, 1000, 0, 0, 20, 0);
        send_item(MODE_ONCE, 1000, 0, 0, 40, 0);
        send_item(MODE_DAILY, 0, 1500, 0, 0, 0);
        send_item(MODE_TICK, 1500, 0, 0, 0, 0);
        wait_drain();
        // free most of the table for the random part
        for (i = 0; i < 12; i++)
            send_item(MODE_REMOVE, 0, 0, 0, 0, i);
        wall_clock = 1500;
    endtask

    task automatic test_random_mix();
        int i;
        for (i = 0; i < 180; i++)
        begin
            send_random_item();
            if (i % 60 == 59)
                wait_drain();
        end
    endtask

    task automatic test_output_hold();
        int i;
        hold_request = 1'b1;
        for (i = 0; i < 30; i++)
            send_random_item();
        wait_drain();
    endtask

    task automatic test_no_idle();
        int i;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        for (i = 0; i < 50; i++)
            send_random_item();
        wait_drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random_mix();
        test_output_hold();
        test_no_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_events.size() != 0)
        begin
            error_count++;
            $display("%0t: results missing, expected %0d more, got none",
                     $time, pending_events.size());
        end
        $display("Covered %0d items and %0d results: %0d starts, %0d stops, %0d table-full.",
                 items_sent, results_seen, starts_seen, stops_seen, full_seen);
        $display("Included midnight windows, daily and long intervals and a long output hold.");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== time_of_day_task_scheduler_top.f =====
rtl/tods_pkg.sv
rtl/tods_mod.sv
rtl/tods_front.sv
rtl/tods_queue.sv
rtl/tods_back.sv
rtl/time_of_day_task_scheduler_top.sv
verif/testbench.sv
